/* rtl/core/mlp_population_inference_unit_assert.svh */
// ---------------------------------------------------------------------------
// MLP population inference - assertion macros
// Concurrent checks on clk with synchronous active-low reset; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef MLP_POPULATION_INFERENCE_UNIT_ASSERT_SVH
`define MLP_POPULATION_INFERENCE_UNIT_ASSERT_SVH

`ifndef SYNTH
// expr must hold at every edge out of reset
`define MLPPI_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mlppi assertion failed");
// cons must hold in the same cycle as ante
`define MLPPI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlppi assertion failed");
`else
`define MLPPI_ASSERT(lbl, expr)
`define MLPPI_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

/* rtl/core/mlppi_pkg.sv */
// ---------------------------------------------------------------------------
// mlppi_pkg
// Shared types, codes and the elaboration-time sigmoid entry generator.
// ---------------------------------------------------------------------------
package mlppi_pkg;

  localparam int unsigned POPULATION_SIZE_DEF     = 10;
  localparam int unsigned HIDDEN_COUNT_DEF        = 5;
  localparam int unsigned SIGMOID_TABLE_DEPTH_DEF = 256;

  // field widths fixed by the interface
  localparam int unsigned GENE_W   = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned ACC_W    = 36;   // 8 * 2^30 + bias, signed
  localparam int unsigned HID_W    = 15;   // ReLU output, 0..32767
  localparam int unsigned ACT_W    = 13;
  localparam int unsigned OFF_W    = 28;   // clamped sum shifted to [0, 2^28)

  // tag field widths, sized for the largest parameter values
  localparam int unsigned MEMBER_W = 6;    // up to 64 members
  localparam int unsigned HIDX_W   = 3;    // up to 8 hidden neurons

  localparam int unsigned RESULT_SLOTS = 2;

  localparam logic signed [GENE_W-1:0] BIAS_ONE = 16'sd4096;

  // gene kinds
  localparam logic [1:0] K_FEAT  = 2'd0;  // hidden input weight
  localparam logic [1:0] K_HBIAS = 2'd1;  // hidden bias, closes a neuron
  localparam logic [1:0] K_OWGT  = 2'd2;  // output weight
  localparam logic [1:0] K_OBIAS = 2'd3;  // output bias, closes a member

  typedef struct packed {
    logic                valid;
    logic [1:0]          kind;
    logic [1:0]          fsel;
    logic [HIDX_W-1:0]   hidx;
    logic                first;
    logic [MEMBER_W-1:0] member;
    logic                last;
  } tag_t;

  typedef struct packed {
    logic                    valid;
    logic [MEMBER_W-1:0]     member;
    logic                    last;
    logic signed [ACC_W-1:0] sum;
  } fin_t;

  typedef struct packed {
    logic             valid;
    logic [3:0]       member;
    logic [ACT_W-1:0] act;
    logic             last;
  } res_t;

  typedef struct packed {
    logic       idle;
    logic [1:0] pend;
  } stat_t;

  // restoring divide, used only to build constants
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int              i;
    q = 64'd0;
    r = 64'd0;
    for (i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 64'd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // sigmoid at the center of bucket k, unsigned Q0.12
  function automatic logic [ACT_W-1:0] sig_entry(int unsigned k, int unsigned depth);
    longint unsigned off;
    longint unsigned mag;
    longint unsigned y;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    longint          acc;
    logic            neg;
    int              n;
    int              i;
    off = udiv64((64'(k) * 64'd2 + 64'd1) * (64'd8 << 24), 64'(depth));
    neg = off < (64'd8 << 24);
    mag = neg ? ((64'd8 << 24) - off) : (off - (64'd8 << 24));
    y = mag << 3;
    term = 64'd1 << 31;
    acc  = 64'sd1 <<< 31;
    for (n = 1; n <= 14; n++) begin
      term = udiv64((term * y) >> 31, 64'(n));
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 31)) acc = 64'sd1 <<< 31;
    e = unsigned'(acc);
    for (i = 0; i < 4; i++) begin
      e = (e * e) >> 31;
    end
    den = (64'd1 << 31) + e;
    s = udiv64((64'd4096 << 31) + (den >> 1), den);
    if (neg) s = 64'd4096 - s;
    return ACT_W'(s);
  endfunction

endpackage

/* rtl/core/mlp_population_inference_unit.sv */
// ---------------------------------------------------------------------------
// mlp_population_inference_unit
// Gene store and evaluator for a population of small 3-H-1 networks.
// ---------------------------------------------------------------------------
//
//  channel  | handshake          | carries
//  ---------+--------------------+----------------------------------------------
//  in_      | in_valid/in_ready  | mode, member/gene index, gene, three features
//  out_     | out_valid/out_ready| result_member, activation, last_member
//
//  A gene write (mode 0) goes into the store; out-of-range indices are dropped.
//  An evaluation (mode 1) reads every gene once through the single store
//  read port, with a bubble before each member's output weights. The last
//  result passes the product, sum, offset, index and table registers and
//  the result queue. No clearing pass after reset.
//  in_ready is high whenever the read sequencer is idle. A stalled output
//  holds the sequencer at the next member start once two results are owed.
//
// ---------------------------------------------------------------------------
`include "mlp_population_inference_unit_assert.svh"

module mlp_population_inference_unit #(
  parameter int unsigned POPULATION_SIZE     = mlppi_pkg::POPULATION_SIZE_DEF,
  parameter int unsigned HIDDEN_COUNT        = mlppi_pkg::HIDDEN_COUNT_DEF,
  parameter int unsigned SIGMOID_TABLE_DEPTH = mlppi_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [3:0]                          in_member_index,
  input  logic [4:0]                          in_gene_index,
  input  logic signed [mlppi_pkg::GENE_W-1:0] in_gene_value,
  input  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_a,
  input  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_b,
  input  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          out_result_member,
  output logic [mlppi_pkg::ACT_W-1:0]         out_activation,
  output logic                                out_last_member
);

  localparam int unsigned GENES = 5 * HIDDEN_COUNT + 1;
  localparam int unsigned DEPTH = POPULATION_SIZE * GENES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic               in_acc;
  logic               start;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [mlppi_pkg::GENE_W-1:0] rdata;
  mlppi_pkg::tag_t    tag;
  mlppi_pkg::stat_t   stat;
  mlppi_pkg::fin_t    fin;
  mlppi_pkg::res_t    res;
  logic               out_pop;

  assign in_acc  = in_valid && in_ready;
  assign start   = in_acc && in_mode;
  assign in_ready = stat.idle;
  assign out_pop = out_valid && out_ready;

  // gene write decode; out-of-range indices write nothing
  assign mem_we    = in_acc && !in_mode &&
                     (7'(in_member_index) < 7'(POPULATION_SIZE)) &&
                     (6'(in_gene_index) < 6'(GENES));
  assign mem_waddr = AW'(in_member_index) * AW'(GENES) + AW'(in_gene_index);

  mlppi_wmem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_gene_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  mlppi_seq #(
    .POPULATION_SIZE (POPULATION_SIZE),
    .HIDDEN_COUNT    (HIDDEN_COUNT),
    .AW              (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .out_pop (out_pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .tag     (tag),
    .stat    (stat)
  );

  mlppi_mac #(
    .HIDDEN_COUNT (HIDDEN_COUNT)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start),
    .feature_a (in_feature_a),
    .feature_b (in_feature_b),
    .feature_c (in_feature_c),
    .tag       (tag),
    .rdata     (rdata),
    .fin       (fin)
  );

  mlppi_act #(
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_act (
    .clk   (clk),
    .rst_n (rst_n),
    .fin   (fin),
    .res   (res)
  );

  // two-entry result queue; the sequencer never owes more than it can hold
  logic [3:0]                  q_member [mlppi_pkg::RESULT_SLOTS];
  logic [mlppi_pkg::ACT_W-1:0] q_act    [mlppi_pkg::RESULT_SLOTS];
  logic                        q_last   [mlppi_pkg::RESULT_SLOTS];
  logic                        wp_r, rp_r;
  logic [1:0]                  cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + 2'(res.valid) - 2'(out_pop);

  always_ff @(posedge clk) begin
    if (res.valid) begin
      q_member[wp_r] <= res.member;
      q_act[wp_r]    <= res.act;
      q_last[wp_r]   <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (res.valid) wp_r <= ~wp_r;
      if (out_pop)   rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_result_member = q_member[rp_r];
  assign out_activation    = q_act[rp_r];
  assign out_last_member   = q_last[rp_r];

  // a result arriving always finds a free slot
  `MLPPI_ASSERT_IMPLY(a_push_has_room, res.valid, cnt_r != 2'(mlppi_pkg::RESULT_SLOTS))
  // queued results are always counted as owed by the sequencer
  `MLPPI_ASSERT(a_pend_covers_queue, cnt_r <= stat.pend)
  // gene writes never overlap an evaluation's reads
  `MLPPI_ASSERT_IMPLY(a_write_not_during_read, mem_we, !rd_en)

endmodule

/* rtl/core/mlppi_wmem.sv */
// ---------------------------------------------------------------------------
// mlppi_wmem
// Gene store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module mlppi_wmem #(
  parameter int unsigned DEPTH = 260,
  parameter int unsigned AW    = 9
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [mlppi_pkg::GENE_W-1:0]   wdata,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr,
  output logic [mlppi_pkg::GENE_W-1:0]   rdata
);

  logic [mlppi_pkg::GENE_W-1:0] mem [DEPTH];
  logic [mlppi_pkg::GENE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mlppi_seq.sv */
// ---------------------------------------------------------------------------
// mlppi_seq
// Walks members and genes, one tagged store read per cycle when not held.
// ---------------------------------------------------------------------------
module mlppi_seq #(
  parameter int unsigned POPULATION_SIZE = mlppi_pkg::POPULATION_SIZE_DEF,
  parameter int unsigned HIDDEN_COUNT    = mlppi_pkg::HIDDEN_COUNT_DEF,
  parameter int unsigned AW              = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_pop,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output mlppi_pkg::tag_t      tag,
  output mlppi_pkg::stat_t     stat
);

  localparam int unsigned GENES = 5 * HIDDEN_COUNT + 1;
  localparam int unsigned GW    = $clog2(GENES);
  localparam int unsigned MW    = (POPULATION_SIZE > 1) ? $clog2(POPULATION_SIZE) : 1;

  localparam logic [GW-1:0] G_HID_END   = GW'(4 * HIDDEN_COUNT);
  localparam logic [GW-1:0] G_LAST_HB   = GW'(4 * HIDDEN_COUNT - 1);
  localparam logic [GW-1:0] G_OBIAS     = GW'(5 * HIDDEN_COUNT);
  localparam logic [GW-1:0] G_LAST      = GW'(GENES - 1);
  localparam logic [MW-1:0] M_LAST      = MW'(POPULATION_SIZE - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;  // bubble so the last hidden value lands

  logic [1:0]    state_r, state_nxt;
  logic [GW-1:0] gene_r, gene_nxt;
  logic [MW-1:0] member_r, member_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic          issue;
  logic          mem_start;

  assign issue     = (state_r == S_RUN) &&
                     !((gene_r == '0) && (pend_r == 2'(mlppi_pkg::RESULT_SLOTS)));
  assign mem_start = issue && (gene_r == '0);

  always_comb begin
    state_nxt  = state_r;
    gene_nxt   = gene_r;
    member_nxt = member_r;
    addr_nxt   = addr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_RUN;
          gene_nxt   = '0;
          member_nxt = '0;
          addr_nxt   = '0;
        end
      end
      S_RUN: begin
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
          gene_nxt = gene_r + 1'b1;
          if (gene_r == G_LAST_HB) begin
            state_nxt = S_HOLD;
          end
          if (gene_r == G_LAST) begin
            gene_nxt = '0;
            if (member_r == M_LAST) begin
              state_nxt = S_IDLE;
            end else begin
              member_nxt = member_r + 1'b1;
            end
          end
        end
      end
      S_HOLD: begin
        state_nxt = S_RUN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    pend_nxt = pend_r + 2'(mem_start) - 2'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gene_r   <= gene_nxt;
    member_r <= member_nxt;
    addr_r   <= addr_nxt;
  end

  // decode the gene position into its role
  always_comb begin
    tag        = '0;
    tag.valid  = issue;
    tag.member = mlppi_pkg::MEMBER_W'(member_r);
    tag.last   = (member_r == M_LAST);
    if (gene_r < G_HID_END) begin
      tag.fsel  = gene_r[1:0];
      tag.hidx  = mlppi_pkg::HIDX_W'(gene_r >> 2);
      tag.kind  = (gene_r[1:0] == 2'd3) ? mlppi_pkg::K_HBIAS : mlppi_pkg::K_FEAT;
      tag.first = (gene_r[1:0] == 2'd0);
    end else if (gene_r < G_OBIAS) begin
      tag.kind  = mlppi_pkg::K_OWGT;
      tag.hidx  = mlppi_pkg::HIDX_W'(gene_r - G_HID_END);
      tag.first = (gene_r == G_HID_END);
    end else begin
      tag.kind  = mlppi_pkg::K_OBIAS;
    end
  end

  assign rd_en     = issue;
  assign rd_addr   = addr_r;
  assign stat.idle = (state_r == S_IDLE);
  assign stat.pend = pend_r;

endmodule

/* rtl/core/mlppi_mac.sv */
// ---------------------------------------------------------------------------
// mlppi_mac
// Operand select, one multiplier, accumulator and hidden-neuron registers.
// ---------------------------------------------------------------------------
module mlppi_mac #(
  parameter int unsigned HIDDEN_COUNT = mlppi_pkg::HIDDEN_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [mlppi_pkg::GENE_W-1:0]  feature_a,
  input  logic signed [mlppi_pkg::GENE_W-1:0]  feature_b,
  input  logic signed [mlppi_pkg::GENE_W-1:0]  feature_c,
  input  mlppi_pkg::tag_t                      tag,
  input  logic [mlppi_pkg::GENE_W-1:0]         rdata,
  output mlppi_pkg::fin_t                      fin
);

  localparam int unsigned HW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;

  logic signed [mlppi_pkg::GENE_W-1:0] feat_r [3];
  logic [mlppi_pkg::HID_W-1:0]         hid_r [HIDDEN_COUNT];
  mlppi_pkg::tag_t                     tag1_r, tag2_r;
  logic signed [mlppi_pkg::GENE_W-1:0] opnd;
  logic signed [mlppi_pkg::PROD_W-1:0] prod_r;
  logic signed [mlppi_pkg::ACC_W-1:0]  acc_r;
  logic signed [mlppi_pkg::ACC_W-1:0]  sum;
  logic signed [mlppi_pkg::ACC_W-1:0]  shifted;
  logic [mlppi_pkg::HID_W-1:0]         relu;
  mlppi_pkg::fin_t                     fin_r;

  always_ff @(posedge clk) begin
    if (load) begin
      feat_r[0] <= feature_a;
      feat_r[1] <= feature_b;
      feat_r[2] <= feature_c;
    end
  end

  // stage 1: gene from the store times the selected operand
  always_comb begin
    case (tag1_r.kind)
      mlppi_pkg::K_FEAT: begin
        case (tag1_r.fsel)
          2'd0:    opnd = feat_r[0];
          2'd1:    opnd = feat_r[1];
          default: opnd = feat_r[2];
        endcase
      end
      mlppi_pkg::K_OWGT: opnd = $signed({1'b0, hid_r[tag1_r.hidx[HW-1:0]]});
      default:           opnd = mlppi_pkg::BIAS_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(rdata) * opnd;
  end

  // stage 2: accumulate, close hidden neurons and members
  assign sum     = tag2_r.first ? mlppi_pkg::ACC_W'(prod_r)
                                : acc_r + mlppi_pkg::ACC_W'(prod_r);
  assign shifted = sum >>> 12;

  always_comb begin
    if (sum[mlppi_pkg::ACC_W-1]) begin
      relu = '0;
    end else if (|shifted[mlppi_pkg::ACC_W-1:mlppi_pkg::HID_W]) begin
      relu = '1;
    end else begin
      relu = shifted[mlppi_pkg::HID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tag2_r.valid) begin
      acc_r <= sum;
      if (tag2_r.kind == mlppi_pkg::K_HBIAS) begin
        hid_r[tag2_r.hidx[HW-1:0]] <= relu;
      end
    end
    if (!rst_n) begin
      fin_r.valid <= 1'b0;
    end else begin
      fin_r.valid <= tag2_r.valid && (tag2_r.kind == mlppi_pkg::K_OBIAS);
    end
    fin_r.member <= tag2_r.member;
    fin_r.last   <= tag2_r.last;
    fin_r.sum    <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag;
      tag2_r <= tag1_r;
    end
  end

  assign fin = fin_r;

endmodule

/* rtl/core/mlppi_act.sv */
// ---------------------------------------------------------------------------
// mlppi_act
// Output clamp, table index scaling and sigmoid lookup.
// ---------------------------------------------------------------------------
module mlppi_act #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = mlppi_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mlppi_pkg::fin_t  fin,
  output mlppi_pkg::res_t  res
);

  localparam int unsigned IW  = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned MUL_W = mlppi_pkg::OFF_W + 13;

  localparam logic signed [mlppi_pkg::ACC_W-1:0] CL_HI = (36'sd1 <<< 27) - 36'sd1;
  localparam logic signed [mlppi_pkg::ACC_W-1:0] CL_LO = -(36'sd1 <<< 27);
  localparam logic [MUL_W-1:0] DEPTH_K = MUL_W'(SIGMOID_TABLE_DEPTH);

  logic [mlppi_pkg::ACT_W-1:0] sig_rom [SIGMOID_TABLE_DEPTH];

  for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [mlppi_pkg::ACT_W-1:0] ENT = mlppi_pkg::sig_entry(k, SIGMOID_TABLE_DEPTH);
    assign sig_rom[k] = ENT;
  end

  logic signed [mlppi_pkg::ACC_W-1:0] clamped;
  logic [mlppi_pkg::OFF_W-1:0]        off_r;
  logic [IW-1:0]                      idx_r;
  logic [MUL_W-1:0]                   scaled;
  logic                               v1_r, v2_r, v3_r;
  logic [3:0]                         mem1_r, mem2_r, mem3_r;
  logic                               last1_r, last2_r, last3_r;
  logic [mlppi_pkg::ACT_W-1:0]        act_r;

  always_comb begin
    if (fin.sum > CL_HI) begin
      clamped = CL_HI;
    end else if (fin.sum < CL_LO) begin
      clamped = CL_LO;
    end else begin
      clamped = fin.sum;
    end
  end

  // clamped + 2^27 lands in [0, 2^28)
  assign scaled = MUL_W'(off_r) * DEPTH_K;

  always_ff @(posedge clk) begin
    off_r   <= clamped[mlppi_pkg::OFF_W-1:0] ^ {1'b1, {(mlppi_pkg::OFF_W-1){1'b0}}};
    mem1_r  <= fin.member[3:0];
    last1_r <= fin.last;
    idx_r   <= scaled[mlppi_pkg::OFF_W +: IW];
    mem2_r  <= mem1_r;
    last2_r <= last1_r;
    act_r   <= sig_rom[idx_r];
    mem3_r  <= mem2_r;
    last3_r <= last2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= fin.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.valid  = v3_r;
  assign res.member = mem3_r;
  assign res.act    = act_r;
  assign res.last   = last3_r;

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top - population inference unit bench
// Fills every gene, walks a directed table, then random writes and
// evaluations; each result is checked against a bit-exact network model.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int   POP          = 10;
  localparam int   HID          = 5;
  localparam int   GENES        = 5 * HID + 1;        // genes per member
  localparam int   STORE_SZ     = POP * GENES;
  localparam int   LUT_SIZE     = 256;
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_EVAL    = 1'b1;
  localparam int   RANDOM_ITEMS = 90;
  localparam int   CHOKE_AFTER  = 8;                  // evaluations before the long stall
  localparam int   CHOKE_CYCLES = 600;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam longint Q24_HI     = (longint'(8) <<< 24) - 1;
  localparam longint Q24_LO     = -(longint'(8) <<< 24);

  // one input item; pin_m0 marks a row whose member 0 activation is typed in
  typedef struct packed {
    logic        mode;
    logic [3:0]  member;
    logic [4:0]  gene;
    logic [15:0] gval;
    logic [15:0] fa;
    logic [15:0] fb;
    logic [15:0] fc;
    logic        pin_m0;
    logic [12:0] m0_act;
  } net_item_t;

  typedef struct packed {
    logic [3:0]                  member;
    logic [mlppi_pkg::ACT_W-1:0] act;
    logic                        last;
  } score_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_mode = 1'b0;
  logic [3:0]                          in_member_index = '0;
  logic [4:0]                          in_gene_index = '0;
  logic signed [mlppi_pkg::GENE_W-1:0] in_gene_value = '0;
  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_a = '0;
  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_b = '0;
  logic signed [mlppi_pkg::GENE_W-1:0] in_feature_c = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [3:0]                          out_result_member;
  logic [mlppi_pkg::ACT_W-1:0]         out_activation;
  logic                                out_last_member;

  // bench-side copy of the gene store and the sigmoid table
  shortint                     gene_mem [STORE_SZ];
  logic [mlppi_pkg::ACT_W-1:0] logistic_lut [LUT_SIZE];
  score_t                      scores_due [$];

  int cycles    = 0;
  int n_faults  = 0;
  int n_writes  = 0;
  int n_dropped = 0;
  int n_evals   = 0;
  int n_scored  = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  mlp_population_inference_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_member_index  (in_member_index),
    .in_gene_index    (in_gene_index),
    .in_gene_value    (in_gene_value),
    .in_feature_a     (in_feature_a),
    .in_feature_b     (in_feature_b),
    .in_feature_c     (in_feature_c),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_member(out_result_member),
    .out_activation   (out_activation),
    .out_last_member  (out_last_member)
  );

  // ---------------------------------------------------------------------
  // Network model
  // ---------------------------------------------------------------------

  // Logistic of a Q.24 argument, as unsigned Q0.12. exp(-|x|/16) comes from
  // a 14-term Taylor series in Q0.31, then four squarings give exp(-|x|).
  function automatic logic [mlppi_pkg::ACT_W-1:0] logistic_q12(longint x);
    longint unsigned mag, y, term, e, den, s, n;
    longint          acc;
    mag = (x < 0) ? -x : x;
    if (mag > (64'd8 << 24)) mag = 64'd8 << 24;
    y    = mag << 3;
    term = 64'd1 << 31;
    acc  = longint'(1) <<< 31;
    for (n = 1; n <= 14; n++) begin
      term = ((term * y) >> 31) / n;
      if (n[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) <<< 31)) acc = longint'(1) <<< 31;
    e = acc;
    repeat (4) e = (e * e) >> 31;
    den = (64'd1 << 31) + e;
    s   = ((64'd4096 << 31) + den / 2) / den;
    if (x < 0) s = 64'd4096 - s;
    return mlppi_pkg::ACT_W'(s);
  endfunction

  // table entry k sits at the center of its bucket over [-8, 8)
  function automatic void build_logistic_lut();
    longint unsigned off;
    for (int k = 0; k < LUT_SIZE; k++) begin
      off = (64'(2 * k + 1) * (64'd8 << 24)) / 64'(LUT_SIZE);
      logistic_lut[k] = logistic_q12(Q24_LO + longint'(off));
    end
  endfunction

  // forward pass of one member: ReLU hidden layer saturated to Q4.12,
  // output clamped to [-8, 8) and looked up in the logistic table
  function automatic logic [mlppi_pkg::ACT_W-1:0] score_member(int m, longint fa, longint fb,
                                                               longint fc);
    longint acc;
    longint hid [HID];
    longint idx;
    int     base;
    base = m * GENES;
    for (int h = 0; h < HID; h++) begin
      acc = fa * gene_mem[base + 4*h] + fb * gene_mem[base + 4*h + 1]
          + fc * gene_mem[base + 4*h + 2] + longint'(gene_mem[base + 4*h + 3]) * 4096;
      if (acc < 0) hid[h] = 0;
      else begin
        acc    = acc >>> 12;
        hid[h] = (acc > 32767) ? 32767 : acc;
      end
    end
    acc = longint'(gene_mem[base + 5*HID]) * 4096;
    for (int h = 0; h < HID; h++) acc = acc + hid[h] * gene_mem[base + 4*HID + h];
    if (acc > Q24_HI) acc = Q24_HI;
    if (acc < Q24_LO) acc = Q24_LO;
    idx = ((acc - Q24_LO) * LUT_SIZE) >>> 28;
    if (idx >= LUT_SIZE) idx = LUT_SIZE - 1;
    return logistic_lut[idx];
  endfunction

  // applied once per accepted item: an in-range write updates the store copy,
  // an evaluation queues one score per member in index order
  function automatic void absorb_item(net_item_t it);
    score_t r;
    if (it.mode == MODE_WRITE) begin
      if (it.member < POP && it.gene < GENES) begin
        gene_mem[int'(it.member) * GENES + int'(it.gene)] = shortint'(it.gval);
        n_writes++;
      end else begin
        n_dropped++;   // out-of-range index, store untouched
      end
    end else begin
      for (int m = 0; m < POP; m++) begin
        r.member = 4'(m);
        r.act    = score_member(m, longint'($signed(it.fa)), longint'($signed(it.fb)),
                                longint'($signed(it.fc)));
        r.last   = (m == POP - 1);
        if (m == 0 && it.pin_m0) r.act = it.m0_act;
        scores_due.push_back(r);
      end
      n_evals++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // mostly small Q4.12 values so the sigmoid sees its middle, some wide ones
  function automatic logic [15:0] rand_q12(int narrow, int wide);
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 16'(int'($urandom_range(0, 2 * narrow)) - narrow);
    if (p < 90) return 16'(int'($urandom_range(0, 2 * wide)) - wide);
    return 16'($urandom);
  endfunction

  function automatic net_item_t step_row(logic mode, int member, int gene, int gval,
                                         int fa, int fb, int fc, bit pin, int act);
    net_item_t it;
    it.mode   = mode;
    it.member = 4'(member);
    it.gene   = 5'(gene);
    it.gval   = 16'(gval);
    it.fa     = 16'(fa);
    it.fb     = 16'(fb);
    it.fc     = 16'(fc);
    it.pin_m0 = pin;
    it.m0_act = 13'(act);
    return it;
  endfunction

  function automatic net_item_t rand_item();
    net_item_t it;
    it.mode = ($urandom_range(0, 99) < 40) ? MODE_EVAL : MODE_WRITE;
    if ($urandom_range(0, 9) == 0) begin
      it.member = 4'($urandom);        // full field, often out of range
      it.gene   = 5'($urandom);
    end else begin
      it.member = 4'($urandom_range(0, POP - 1));
      it.gene   = 5'($urandom_range(0, GENES - 1));
    end
    it.gval   = rand_q12(1024, 8192);
    it.fa     = rand_q12(4096, 16384);
    it.fb     = rand_q12(4096, 16384);
    it.fc     = rand_q12(4096, 16384);
    it.pin_m0 = 1'b0;
    it.m0_act = '0;
    return it;
  endfunction

  // sender pacing: bursts of random length, random gaps, some long bursts
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input net_item_t it);
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_member_index <= it.member;
    in_gene_index   <= it.gene;
    in_gene_value   <= it.gval;
    in_feature_a    <= it.fa;
    in_feature_b    <= it.fb;
    in_feature_c    <= it.fc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_item(it);
    @(negedge clk);
  endtask

  task automatic log_fault(input string what);
    n_faults++;
    if (n_faults <= 10) $display("[%0d] MISMATCH: %s", cycles, what);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    net_item_t dir_rows [$];
    net_item_t it;
    int        fill_order [STORE_SZ];
    int        j, t;

    build_logistic_lut();
    foreach (gene_mem[i]) gene_mem[i] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every gene is written once, in shuffled order, before any evaluation:
    // the store holds nothing defined until written.
    for (int i = 0; i < STORE_SZ; i++) fill_order[i] = i;
    for (int i = STORE_SZ - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = t;
    end
    for (int i = 0; i < STORE_SZ; i++) begin
      it = rand_item();
      it.mode   = MODE_WRITE;
      it.member = 4'(fill_order[i] / GENES);
      it.gene   = 5'(fill_order[i] % GENES);
      pace();
      offer(it);
    end

    // Directed table. Member 0 gets zero output weights, so its output is
    // just the output bias: max bias lands on the top table entry (4095),
    // min bias exactly on the lower clamp, i.e. the bottom entry (1).
    dir_rows.push_back(step_row(MODE_WRITE, 0, 20, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 21, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 22, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 23, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 24, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 25, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, 0, 0, 0, 1, 4095));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 25, -32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, 32767, 32767, 32767, 1, 1));
    // out-of-range writes must leave the store alone
    dir_rows.push_back(step_row(MODE_WRITE, 10, 0, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 15, 31, -1, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 0, 26, 12345, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 9, 31, -32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 15, 31, -1, -32768, -32768, -32768, 1, 1));
    // member 9: hidden neuron 0 saturates, then is driven negative and cut to zero by ReLU
    dir_rows.push_back(step_row(MODE_WRITE, 9, 0, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 9, 3, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 9, 20, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, 32767, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 9, 0, -32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, 32767, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, -32768, 32767, -1, 0, 0));
    dir_rows.push_back(step_row(MODE_WRITE, 5, 12, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(step_row(MODE_EVAL, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      pace();
      offer(dir_rows[i]);
    end

    // random writes and evaluations; the sink's long stall lands in here
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pace();
      offer(rand_item());
    end
    in_valid <= 1'b0;

    while (scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d gene writes (%0d dropped out of range), %0d evaluations,",
             n_writes, n_dropped, n_evals);
    $display("%0d member results checked, %0d faults, %0d cycles.", n_scored, n_faults, cycles);
    if (n_faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result sink: own stall pattern, plus one long hold-off once CHOKE_AFTER
  // evaluations have been accepted, so the unit backs up into its input.
  // ---------------------------------------------------------------------
  initial begin : sink_pacing
    int cyc;
    int style;
    bit choked;
    cyc    = 0;
    style  = 0;
    choked = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!choked && n_evals >= CHOKE_AFTER) begin
        choked = 1'b1;
        out_ready <= 1'b0;
        for (int hold = 0; hold < CHOKE_CYCLES; hold++) @(negedge clk);
      end
      if (cyc % 97 == 0) style = $urandom_range(0, 3);
      case (style)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ((cyc % 7) < 4);
        end
      endcase
    end
  end

  // compare each accepted result with the oldest queued score
  always @(posedge clk) begin : score_check
    score_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scores_due.size() == 0) begin
        log_fault($sformatf("unexpected result member=%0d act=%0d last=%0d",
                            out_result_member, out_activation, out_last_member));
      end else begin
        want = scores_due.pop_front();
        n_scored++;
        if (out_result_member !== want.member || out_activation !== want.act ||
            out_last_member !== want.last) begin
          log_fault($sformatf("exp member=%0d act=%0d last=%0d, got member=%0d act=%0d last=%0d",
                              want.member, want.act, want.last,
                              out_result_member, out_activation, out_last_member));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, scores_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
